// ----- rtl/htq_pkg.sv -----
// Shared types and codes for the heap timer queue.
package htq_pkg;

  localparam logic [1:0] ACT_REGISTER   = 2'd0;
  localparam logic [1:0] ACT_ARM        = 2'd1;
  localparam logic [1:0] ACT_UNREGISTER = 2'd2;
  localparam logic [1:0] ACT_POLL       = 2'd3;

  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_STALE = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  slot;
    logic [31:0] generation;
    logic [63:0] deadline;
    logic [63:0] now_time;
    logic [5:0]  max_expiries;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [5:0]  token_slot;
    logic [31:0] token_generation;
    logic [63:0] earliest_deadline;
    logic [5:0]  expired_count;
    logic        more_due;
    logic        last;
  } res_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_EXEC,
    S_TAKE, S_TAKE1, S_TAKE2,
    S_UP0, S_UP1, S_UP2,
    S_DN0, S_DN1, S_DN2, S_DN3, S_DN4,
    S_PLACE,
    S_TOP0, S_TOP1, S_TOP2, S_TOPCHK,
    S_EX0, S_EX1, S_EX2, S_SUM, S_REPLY
  } state_t;

  typedef struct packed {
    state_t op;
    logic   accept;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic is_poll;
    logic exec_take;
    logic exec_sift;
    logic take_last;
    logic pos_root;
    logic up_earlier;
    logic l_out;
    logic r_in;
    logic dn_earlier;
    logic heap_empty;
    logic expire_go;
    logic ex_done;
    logic out_free;
  } flags_t;

endpackage

// ----- rtl/htq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module htq_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/htq_ctrl.sv -----
// Sequencer for the heap timer queue: one state per micro-step.
module htq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  logic            cfg_we,
  input  htq_pkg::flags_t flags,
  output htq_pkg::ctl_t   ctl
);

  htq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htq_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd_stall  = (state != htq_pkg::S_IDLE);
    ctl.op     = state;
    ctl.accept = cmd_valid && (state == htq_pkg::S_IDLE);
    state_next = state;
    unique case (state)
      htq_pkg::S_CLEAR:  if (flags.clr_last) state_next = htq_pkg::S_IDLE;
      htq_pkg::S_IDLE:   if (cmd_valid) state_next = htq_pkg::S_DECODE;
      htq_pkg::S_DECODE: state_next = flags.is_poll ? htq_pkg::S_TOP0 : htq_pkg::S_EXEC;
      htq_pkg::S_EXEC: begin
        priority if (flags.exec_take) state_next = htq_pkg::S_TAKE;
        else if (flags.exec_sift) state_next = htq_pkg::S_UP0;
        else state_next = htq_pkg::S_TOP0;
      end
      htq_pkg::S_TAKE:  state_next = flags.take_last ? htq_pkg::S_TOP0 : htq_pkg::S_TAKE1;
      htq_pkg::S_TAKE1: state_next = htq_pkg::S_TAKE2;
      htq_pkg::S_TAKE2: state_next = htq_pkg::S_UP0;
      htq_pkg::S_UP0:   state_next = flags.pos_root ? htq_pkg::S_DN0 : htq_pkg::S_UP1;
      htq_pkg::S_UP1:   state_next = htq_pkg::S_UP2;
      htq_pkg::S_UP2:   state_next = flags.up_earlier ? htq_pkg::S_UP0 : htq_pkg::S_DN0;
      htq_pkg::S_DN0:   state_next = flags.l_out ? htq_pkg::S_PLACE : htq_pkg::S_DN1;
      htq_pkg::S_DN1:   state_next = htq_pkg::S_DN2;
      htq_pkg::S_DN2:   state_next = flags.r_in ? htq_pkg::S_DN3 : htq_pkg::S_DN4;
      htq_pkg::S_DN3:   state_next = htq_pkg::S_DN4;
      htq_pkg::S_DN4:   state_next = flags.dn_earlier ? htq_pkg::S_DN0 : htq_pkg::S_PLACE;
      htq_pkg::S_PLACE: state_next = htq_pkg::S_TOP0;
      htq_pkg::S_TOP0:  state_next = flags.heap_empty ? htq_pkg::S_TOPCHK : htq_pkg::S_TOP1;
      htq_pkg::S_TOP1:  state_next = htq_pkg::S_TOP2;
      htq_pkg::S_TOP2:  state_next = htq_pkg::S_TOPCHK;
      htq_pkg::S_TOPCHK: begin
        priority if (flags.expire_go) state_next = htq_pkg::S_TAKE;
        else if (flags.is_poll) state_next = htq_pkg::S_EX0;
        else state_next = htq_pkg::S_REPLY;
      end
      htq_pkg::S_EX0:   state_next = flags.ex_done ? htq_pkg::S_SUM : htq_pkg::S_EX1;
      htq_pkg::S_EX1:   state_next = htq_pkg::S_EX2;
      htq_pkg::S_EX2:   if (flags.out_free) state_next = htq_pkg::S_EX0;
      htq_pkg::S_SUM:   if (flags.out_free) state_next = htq_pkg::S_IDLE;
      htq_pkg::S_REPLY: if (flags.out_free) state_next = htq_pkg::S_IDLE;
      default:          state_next = htq_pkg::S_CLEAR;
    endcase
    // A configuration write sends the sequencer back to the clearing pass.
    if (cfg_we) begin
      state_next = htq_pkg::S_CLEAR;
    end
  end

endmodule

// ----- rtl/htq_datapath.sv -----
// Slot tables, heap storage and result register of the heap timer queue.
module htq_datapath #(
  parameter int SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  htq_pkg::ctl_t   ctl,
  input  htq_pkg::cmd_t   cmd,
  input  logic            cfg_we,
  input  logic [6:0]      cfg_data,
  input  logic            res_stall,
  output logic            res_valid,
  output htq_pkg::res_t   res,
  output htq_pkg::flags_t flags
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int XW = IW + 2;
  localparam int CW = (PW > 7) ? PW : 7;
  localparam int EXP_DEPTH = 64;
  localparam logic [PW-1:0] NONE = PW'(SLOTS);

  function automatic logic earlier(input logic [63:0] da, input logic [IW-1:0] sa,
                                   input logic [63:0] db, input logic [IW-1:0] sb);
    earlier = (da < db) || ((da == db) && (sa < sb));
  endfunction

  htq_pkg::cmd_t inr;
  logic [PW-1:0] count, hsize, fhead;
  logic [IW-1:0] clr, pos, gone, ms, cs, rs, cidx, ts, rslot;
  logic [63:0]   md, cd, top;
  logic [5:0]    cnt, k;
  logic [1:0]    rstat;
  logic [31:0]   rgen;

  // RAM ports
  logic          dl_we, gen_we, used_we, hpos_we, nfree_we, heap_we, exp_we;
  logic [IW-1:0] dl_wa, gen_wa, used_wa, hpos_wa, nfree_wa, heap_wa;
  logic [IW-1:0] dl_ra, gen_ra, slot_ra, heap_ra;
  logic [5:0]    exp_wa, exp_ra;
  logic [63:0]   dl_wd, dl_rd;
  logic [31:0]   gen_wd, gen_rd;
  logic          used_wd, used_rd;
  logic [PW-1:0] hpos_wd, hpos_rd, nfree_wd, nfree_rd;
  logic [IW-1:0] heap_wd, heap_rd, exp_wd, exp_rd;

  logic [IW-1:0] sidx, parent;
  logic [XW-1:0] lidx;
  logic [31:0]   gen_new;
  logic [CW-1:0] cfg_clamped;
  logic          tok_ok, in_heap, no_free, more;

  htq_ram #(.W(64), .D(SLOTS)) u_dl (.clk(clk), .we(dl_we), .waddr(dl_wa),
    .wdata(dl_wd), .raddr(dl_ra), .rdata(dl_rd));
  htq_ram #(.W(32), .D(SLOTS)) u_gen (.clk(clk), .we(gen_we), .waddr(gen_wa),
    .wdata(gen_wd), .raddr(gen_ra), .rdata(gen_rd));
  htq_ram #(.W(1), .D(SLOTS)) u_used (.clk(clk), .we(used_we), .waddr(used_wa),
    .wdata(used_wd), .raddr(slot_ra), .rdata(used_rd));
  htq_ram #(.W(PW), .D(SLOTS)) u_hpos (.clk(clk), .we(hpos_we), .waddr(hpos_wa),
    .wdata(hpos_wd), .raddr(slot_ra), .rdata(hpos_rd));
  htq_ram #(.W(PW), .D(SLOTS)) u_nfree (.clk(clk), .we(nfree_we), .waddr(nfree_wa),
    .wdata(nfree_wd), .raddr(slot_ra), .rdata(nfree_rd));
  htq_ram #(.W(IW), .D(SLOTS)) u_heap (.clk(clk), .we(heap_we), .waddr(heap_wa),
    .wdata(heap_wd), .raddr(heap_ra), .rdata(heap_rd));
  htq_ram #(.W(IW), .D(EXP_DEPTH)) u_exp (.clk(clk), .we(exp_we), .waddr(exp_wa),
    .wdata(exp_wd), .raddr(exp_ra), .rdata(exp_rd));

  assign sidx    = IW'(inr.slot);
  assign parent  = (pos - IW'(1)) >> 1;
  assign lidx    = XW'({pos, 1'b1});
  assign gen_new = (gen_rd + 32'd1 == 32'd0) ? 32'd1 : gen_rd + 32'd1;
  assign tok_ok  = (CW'(inr.slot) < CW'(count)) && used_rd && (gen_rd == inr.generation);
  assign in_heap = (hpos_rd != NONE);
  assign no_free = (fhead == NONE);
  assign more    = (hsize != '0) && (top <= inr.now_time);

  always_comb begin
    if (cfg_data == 7'd0) begin
      cfg_clamped = CW'(1);
    end else if (CW'(cfg_data) > CW'(SLOTS)) begin
      cfg_clamped = CW'(SLOTS);
    end else begin
      cfg_clamped = CW'(cfg_data);
    end
  end

  always_comb begin
    flags.clr_last   = (clr == IW'(SLOTS - 1));
    flags.is_poll    = (inr.action == htq_pkg::ACT_POLL);
    flags.exec_take  = 1'b0;
    flags.exec_sift  = 1'b0;
    if (tok_ok && inr.action == htq_pkg::ACT_ARM) begin
      flags.exec_take = (inr.deadline == 64'd0) && in_heap;
      flags.exec_sift = (inr.deadline != 64'd0) && (in_heap || (hsize < count));
    end else if (tok_ok && inr.action == htq_pkg::ACT_UNREGISTER) begin
      flags.exec_take = in_heap;
    end
    flags.take_last  = (PW'(pos) == hsize - PW'(1));
    flags.pos_root   = (pos == '0);
    flags.up_earlier = earlier(md, ms, dl_rd, cs);
    flags.l_out      = (lidx >= XW'(hsize));
    flags.r_in       = (lidx + XW'(1) < XW'(hsize));
    flags.dn_earlier = earlier(cd, cs, md, ms);
    flags.heap_empty = (hsize == '0);
    flags.expire_go  = flags.is_poll && (cnt < inr.max_expiries) && more;
    flags.ex_done    = (k == cnt);
    flags.out_free   = !res_valid || !res_stall;
  end

  // RAM port control
  always_comb begin
    dl_we = 1'b0;    dl_wa = sidx;    dl_wd = 64'd0;
    gen_we = 1'b0;   gen_wa = sidx;   gen_wd = gen_new;
    used_we = 1'b0;  used_wa = sidx;  used_wd = 1'b0;
    hpos_we = 1'b0;  hpos_wa = sidx;  hpos_wd = NONE;
    nfree_we = 1'b0; nfree_wa = sidx; nfree_wd = fhead;
    heap_we = 1'b0;  heap_wa = pos;   heap_wd = cs;
    exp_we = 1'b0;   exp_wa = cnt;    exp_wd = ts;
    dl_ra   = sidx;
    gen_ra  = sidx;
    slot_ra = sidx;
    heap_ra = '0;
    exp_ra  = k;
    unique case (ctl.op)
      htq_pkg::S_CLEAR: begin
        dl_we = 1'b1;    dl_wa = clr;
        gen_we = 1'b1;   gen_wa = clr;   gen_wd = 32'd0;
        used_we = 1'b1;  used_wa = clr;
        hpos_we = 1'b1;  hpos_wa = clr;
        nfree_we = 1'b1; nfree_wa = clr;
        nfree_wd = (PW'(clr) + PW'(1) < count) ? PW'(clr) + PW'(1) : NONE;
      end
      htq_pkg::S_DECODE: begin
        if (inr.action == htq_pkg::ACT_REGISTER) begin
          gen_ra  = IW'(fhead);
          slot_ra = IW'(fhead);
        end
      end
      htq_pkg::S_EXEC: begin
        unique case (inr.action)
          htq_pkg::ACT_REGISTER: begin
            if (!no_free) begin
              gen_we = 1'b1;  gen_wa = IW'(fhead);
              dl_we = 1'b1;   dl_wa = IW'(fhead);
              hpos_we = 1'b1; hpos_wa = IW'(fhead);
              used_we = 1'b1; used_wa = IW'(fhead); used_wd = 1'b1;
            end
          end
          htq_pkg::ACT_ARM: begin
            dl_we = tok_ok;
            dl_wd = inr.deadline;
          end
          htq_pkg::ACT_UNREGISTER: begin
            dl_we    = tok_ok;
            used_we  = tok_ok;
            nfree_we = tok_ok;
          end
          default: ;
        endcase
      end
      htq_pkg::S_TAKE: begin
        hpos_we = 1'b1; hpos_wa = gone;
        heap_ra = IW'(hsize - PW'(1));
      end
      htq_pkg::S_TAKE1: dl_ra = heap_rd;
      htq_pkg::S_UP0:   heap_ra = parent;
      htq_pkg::S_UP1:   dl_ra = heap_rd;
      htq_pkg::S_UP2: begin
        if (flags.up_earlier) begin
          heap_we = 1'b1;
          hpos_we = 1'b1; hpos_wa = cs; hpos_wd = PW'(pos);
        end
      end
      htq_pkg::S_DN0: heap_ra = IW'(lidx);
      htq_pkg::S_DN1: begin
        dl_ra   = heap_rd;
        heap_ra = IW'(lidx + XW'(1));
      end
      htq_pkg::S_DN2: dl_ra = heap_rd;
      htq_pkg::S_DN4: begin
        if (flags.dn_earlier) begin
          heap_we = 1'b1;
          hpos_we = 1'b1; hpos_wa = cs; hpos_wd = PW'(pos);
        end
      end
      htq_pkg::S_PLACE: begin
        heap_we = 1'b1; heap_wd = ms;
        hpos_we = 1'b1; hpos_wa = ms; hpos_wd = PW'(pos);
      end
      htq_pkg::S_TOP1: dl_ra = heap_rd;
      htq_pkg::S_TOPCHK: begin
        if (flags.expire_go) begin
          exp_we = 1'b1;
          dl_we = 1'b1; dl_wa = ts;
        end
      end
      htq_pkg::S_EX1: gen_ra = exp_rd;
      htq_pkg::S_EX2: gen_ra = ts;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= NONE;
      hsize     <= '0;
      fhead     <= '0;
      clr       <= '0;
      res_valid <= 1'b0;
    end else if (cfg_we) begin
      count <= PW'(cfg_clamped);
      hsize <= '0;
      fhead <= '0;
      clr   <= '0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (ctl.op)
        htq_pkg::S_CLEAR: clr <= clr + IW'(1);
        htq_pkg::S_EXEC: begin
          if (inr.action == htq_pkg::ACT_REGISTER && !no_free) begin
            fhead <= nfree_rd;
          end else if (inr.action == htq_pkg::ACT_UNREGISTER && tok_ok) begin
            fhead <= PW'(sidx);
          end else if (inr.action == htq_pkg::ACT_ARM && flags.exec_sift && !in_heap) begin
            hsize <= hsize + PW'(1);
          end
        end
        htq_pkg::S_TAKE: hsize <= hsize - PW'(1);
        htq_pkg::S_EX2, htq_pkg::S_SUM, htq_pkg::S_REPLY: begin
          if (flags.out_free) begin
            res_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      inr <= cmd;
    end
    unique case (ctl.op)
      htq_pkg::S_DECODE: cnt <= '0;
      htq_pkg::S_EXEC: begin
        rstat <= htq_pkg::STAT_OK;
        rslot <= '0;
        rgen  <= 32'd0;
        gone  <= sidx;
        ms    <= sidx;
        md    <= inr.deadline;
        pos   <= in_heap ? IW'(hpos_rd) : IW'(hsize);
        unique case (inr.action)
          htq_pkg::ACT_REGISTER: begin
            if (no_free) begin
              rstat <= htq_pkg::STAT_FULL;
            end else begin
              rslot <= IW'(fhead);
              rgen  <= gen_new;
            end
          end
          htq_pkg::ACT_ARM, htq_pkg::ACT_UNREGISTER: begin
            if (!tok_ok) begin
              rstat <= htq_pkg::STAT_STALE;
            end else if (inr.action == htq_pkg::ACT_ARM && inr.deadline != 64'd0 &&
                         !in_heap && hsize >= count) begin
              rstat <= htq_pkg::STAT_FULL;
            end
          end
          default: ;
        endcase
      end
      htq_pkg::S_TAKE1: ms <= heap_rd;
      htq_pkg::S_TAKE2: md <= dl_rd;
      htq_pkg::S_UP1:   cs <= heap_rd;
      htq_pkg::S_UP2:   if (flags.up_earlier) pos <= parent;
      htq_pkg::S_DN1: begin
        cs   <= heap_rd;
        cidx <= IW'(lidx);
      end
      htq_pkg::S_DN2: begin
        cd <= dl_rd;
        rs <= heap_rd;
      end
      htq_pkg::S_DN3: begin
        if (earlier(dl_rd, rs, cd, cs)) begin
          cs   <= rs;
          cd   <= dl_rd;
          cidx <= IW'(lidx + XW'(1));
        end
      end
      htq_pkg::S_DN4: if (flags.dn_earlier) pos <= cidx;
      htq_pkg::S_TOP0:  if (flags.heap_empty) top <= 64'd0;
      htq_pkg::S_TOP1:  ts <= heap_rd;
      htq_pkg::S_TOP2:  top <= dl_rd;
      htq_pkg::S_TOPCHK: begin
        k <= '0;
        if (flags.expire_go) begin
          gone <= ts;
          pos  <= '0;
          cnt  <= cnt + 6'd1;
        end
      end
      htq_pkg::S_EX1: ts <= exp_rd;
      htq_pkg::S_EX2: if (flags.out_free) k <= k + 6'd1;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (flags.out_free) begin
      res.earliest_deadline <= top;
      unique case (ctl.op)
        htq_pkg::S_REPLY: begin
          res.kind             <= htq_pkg::KIND_REPLY;
          res.status           <= rstat;
          res.token_slot       <= 6'(rslot);
          res.token_generation <= rgen;
          res.expired_count    <= 6'd0;
          res.more_due         <= 1'b0;
          res.last             <= 1'b1;
        end
        htq_pkg::S_EX2: begin
          res.kind             <= htq_pkg::KIND_EXPIRED;
          res.status           <= htq_pkg::STAT_OK;
          res.token_slot       <= 6'(ts);
          res.token_generation <= gen_rd;
          res.expired_count    <= 6'd0;
          res.more_due         <= 1'b0;
          res.last             <= 1'b0;
        end
        htq_pkg::S_SUM: begin
          res.kind             <= htq_pkg::KIND_SUMMARY;
          res.status           <= htq_pkg::STAT_OK;
          res.token_slot       <= 6'd0;
          res.token_generation <= 32'd0;
          res.expired_count    <= cnt;
          res.more_due         <= more;
          res.last             <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/heap_timer_queue.sv -----
// Top level of the heap timer queue: sequencer plus datapath.
//
// Commands arrive on cmd_valid/cmd_stall, one beat per command; results leave
// on res_valid/res_stall, one beat per result, with last set on the final one.
// Register, arm and unregister give one reply; poll gives one beat per
// expired timer and then a summary. One command is worked on at a time.
// An arm that places or moves a timer walks it up and then down the heap; a
// removal from the heap moves the last entry into the gap and walks it the
// same way, unless the removed entry sat in the last place. A poll removes
// each expired timer from the top of the heap in turn, then sends its beats.
// Every level of the heap walk needs two dependent table reads before its
// compare. A new command is taken while the last result still sits in the
// output register. When the receiver stalls, the sequencer holds at the next
// result until the register frees up.
// After reset and after every slot_count write, a clearing pass over all SLOTS
// entries initializes the slot tables; commands are stalled meanwhile.
module heap_timer_queue #(
  parameter int SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  htq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output htq_pkg::res_t res,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_data
);

  htq_pkg::ctl_t   ctl;
  htq_pkg::flags_t flags;

  htq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .cfg_we(cfg_we), .flags(flags), .ctl(ctl)
  );

  htq_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .cmd(cmd), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .res_stall(res_stall), .res_valid(res_valid),
    .res(res), .flags(flags)
  );

endmodule

// ----- rtl/htq_check.sv -----
// Port-level checks for the heap timer queue, bound to the top level.
module htq_check (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input logic          res_valid,
  input logic          res_stall,
  input htq_pkg::res_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while the previous one is still open");

  a_expired_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == htq_pkg::KIND_EXPIRED |-> !res.last)
    else $error("expired timer beat closed a poll");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == htq_pkg::KIND_SUMMARY || res.kind == htq_pkg::KIND_REPLY)
    |-> res.last)
    else $error("reply or summary beat without last");

endmodule

bind heap_timer_queue htq_check u_check (.*);

// ----- test/heap_timer_queue_tb.sv -----
// Self-checking testbench for the heap timer queue with a built-in heap predictor.
module heap_timer_queue_tb;

  localparam int NSLOT = 64;
  localparam int NONE = 64;
  localparam longint unsigned LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  htq_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  htq_pkg::res_t res;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  heap_timer_queue dut (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  int unsigned    live_slots;
  logic [63:0]    tmr_deadline [NSLOT];
  logic [31:0]    tmr_gen [NSLOT];
  bit             tmr_used [NSLOT];
  int unsigned    tmr_pos [NSLOT];
  int unsigned    tmr_next [NSLOT];
  int unsigned    spare_head;
  int unsigned    heap [NSLOT];
  int unsigned    heap_cnt;

  htq_pkg::res_t pending_results [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_seen = 0;
  int expiries_seen = 0;
  longint unsigned cycles = 0;

  function automatic void clear_timers(int unsigned cnt);
    for (int i = 0; i < NSLOT; i++) begin
      tmr_deadline[i] = '0;
      tmr_gen[i] = '0;
      tmr_used[i] = 1'b0;
      tmr_pos[i] = NONE;
      tmr_next[i] = (i + 1 < cnt) ? i + 1 : NONE;
      heap[i] = 0;
    end
    spare_head = 0;
    heap_cnt = 0;
  endfunction

  function automatic bit sooner(int unsigned a, int unsigned b);
    if (tmr_deadline[a] != tmr_deadline[b]) return tmr_deadline[a] < tmr_deadline[b];
    return a < b;
  endfunction

  function automatic void heap_swap(int unsigned a, int unsigned b);
    int unsigned t;
    t = heap[a];
    heap[a] = heap[b];
    heap[b] = t;
    tmr_pos[heap[a]] = a;
    tmr_pos[heap[b]] = b;
  endfunction

  function automatic void bubble_up(int unsigned p);
    int unsigned par;
    while (p != 0) begin
      par = (p - 1) / 2;
      if (!sooner(heap[p], heap[par])) break;
      heap_swap(p, par);
      p = par;
    end
  endfunction

  function automatic void bubble_down(int unsigned p);
    int unsigned l, r, best;
    forever begin
      l = 2 * p + 1;
      r = l + 1;
      best = p;
      if (l < heap_cnt && sooner(heap[l], heap[best])) best = l;
      if (r < heap_cnt && sooner(heap[r], heap[best])) best = r;
      if (best == p) break;
      heap_swap(p, best);
      p = best;
    end
  endfunction

  function automatic void heap_remove(int unsigned p);
    int unsigned gone, moved;
    if (p >= heap_cnt) return;
    gone = heap[p];
    heap_cnt--;
    if (p != heap_cnt) begin
      moved = heap[heap_cnt];
      heap[p] = moved;
      tmr_pos[moved] = p;
      bubble_up(p);
      bubble_down(tmr_pos[moved]);
    end
    tmr_pos[gone] = NONE;
  endfunction

  function automatic bit token_valid(logic [5:0] s, logic [31:0] g);
    return s < live_slots && tmr_used[s] && tmr_gen[s] == g;
  endfunction

  function automatic void set_slot_count(logic [6:0] v);
    int unsigned n;
    n = v;
    if (n == 0) n = 1;
    if (n > NSLOT) n = NSLOT;
    live_slots = n;
    clear_timers(n);
  endfunction

  function automatic htq_pkg::res_t mk(logic [1:0] k, logic [1:0] st);
    htq_pkg::res_t r;
    r = '0;
    r.kind = k;
    r.status = st;
    return r;
  endfunction

  // Applies one command to the predictor and queues its results.
  function automatic void predict_command(htq_pkg::cmd_t c);
    htq_pkg::res_t outq [$];
    htq_pkg::res_t r;
    int unsigned sl, p;
    logic [31:0] gen;
    logic [63:0] old, top;
    logic [1:0] st;
    int unsigned cnt;
    case (c.action)
      htq_pkg::ACT_REGISTER: begin
        if (spare_head >= NONE) begin
          outq.push_back(mk(htq_pkg::KIND_REPLY, htq_pkg::STAT_FULL));
        end else begin
          sl = spare_head;
          gen = tmr_gen[sl] + 32'd1;
          if (gen == 0) gen = 32'd1;
          spare_head = tmr_next[sl];
          tmr_gen[sl] = gen;
          tmr_deadline[sl] = '0;
          tmr_pos[sl] = NONE;
          tmr_used[sl] = 1'b1;
          r = mk(htq_pkg::KIND_REPLY, htq_pkg::STAT_OK);
          r.token_slot = 6'(sl);
          r.token_generation = gen;
          outq.push_back(r);
        end
      end
      htq_pkg::ACT_ARM: begin
        st = htq_pkg::STAT_OK;
        if (!token_valid(c.slot, c.generation)) st = htq_pkg::STAT_STALE;
        else begin
          sl = c.slot;
          old = tmr_deadline[sl];
          tmr_deadline[sl] = c.deadline;
          if (c.deadline == 0) begin
            if (tmr_pos[sl] != NONE) heap_remove(tmr_pos[sl]);
          end else if (tmr_pos[sl] == NONE) begin
            if (heap_cnt >= live_slots) st = htq_pkg::STAT_FULL;
            else begin
              p = heap_cnt++;
              heap[p] = sl;
              tmr_pos[sl] = p;
              bubble_up(p);
            end
          end else begin
            p = tmr_pos[sl];
            if (old == 0 || c.deadline < old) bubble_up(p);
            else if (c.deadline > old) bubble_down(p);
          end
        end
        outq.push_back(mk(htq_pkg::KIND_REPLY, st));
      end
      htq_pkg::ACT_UNREGISTER: begin
        st = htq_pkg::STAT_OK;
        if (!token_valid(c.slot, c.generation)) st = htq_pkg::STAT_STALE;
        else begin
          sl = c.slot;
          if (tmr_pos[sl] != NONE) heap_remove(tmr_pos[sl]);
          tmr_deadline[sl] = '0;
          tmr_used[sl] = 1'b0;
          tmr_next[sl] = spare_head;
          spare_head = sl;
        end
        outq.push_back(mk(htq_pkg::KIND_REPLY, st));
      end
      default: begin
        cnt = 0;
        while (cnt < c.max_expiries && heap_cnt != 0) begin
          sl = heap[0];
          if (tmr_deadline[sl] > c.now_time) break;
          r = mk(htq_pkg::KIND_EXPIRED, htq_pkg::STAT_OK);
          r.token_slot = 6'(sl);
          r.token_generation = tmr_gen[sl];
          outq.push_back(r);
          heap_remove(0);
          tmr_deadline[sl] = '0;
          cnt++;
        end
        r = mk(htq_pkg::KIND_SUMMARY, htq_pkg::STAT_OK);
        r.expired_count = 6'(cnt);
        r.more_due = heap_cnt != 0 && tmr_deadline[heap[0]] <= c.now_time;
        outq.push_back(r);
      end
    endcase
    top = heap_cnt != 0 ? tmr_deadline[heap[0]] : '0;
    foreach (outq[i]) begin
      outq[i].earliest_deadline = top;
      outq[i].last = (i == outq.size() - 1);
      pending_results.push_back(outq[i]);
    end
  endfunction

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    htq_pkg::res_t want;
    cycles <= cycles + 1;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        beats_seen++;
        if (res.kind == htq_pkg::KIND_EXPIRED) expiries_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: expected none actual %p", $time, res);
        end else begin
          want = pending_results.pop_front();
          if (res !== want) begin
            errors++;
            $display("%0t result mismatch: expected %p actual %p", $time, want, res);
          end
        end
      end
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
    if (cycles > LIMIT) begin
      $display("heap_timer_queue regression: fail");
      $finish;
    end
  end

  // Sends one command beat and records its expected results on acceptance.
  // Valid stays high after a beat so that the next one can follow directly.
  task automatic send_command(htq_pkg::cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    predict_command(c);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_slot_count(logic [6:0] v);
    drain_results();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_slot_count(v);
  endtask

  // Directed rows; a typed expectation is checked against the predictor's.
  typedef struct {
    htq_pkg::cmd_t c;
    bit            has_exp;
    htq_pkg::res_t first;
  } row_t;

  function automatic htq_pkg::cmd_t mkc(logic [1:0] a, logic [5:0] s, logic [31:0] g,
                                        logic [63:0] d, logic [63:0] n, logic [5:0] m);
    htq_pkg::cmd_t c;
    c.action = a;
    c.slot = s;
    c.generation = g;
    c.deadline = d;
    c.now_time = n;
    c.max_expiries = m;
    return c;
  endfunction

  function automatic htq_pkg::cmd_t random_command();
    htq_pkg::cmd_t c;
    int unsigned pick, sl;
    c = '0;
    c.generation = $urandom;
    c.deadline = {$urandom, $urandom};
    c.now_time = {$urandom, $urandom};
    c.max_expiries = 6'($urandom_range(63));
    c.slot = 6'($urandom_range(63));
    pick = $urandom_range(99);
    if (pick < 20) c.action = htq_pkg::ACT_REGISTER;
    else if (pick < 60) c.action = htq_pkg::ACT_ARM;
    else if (pick < 75) c.action = htq_pkg::ACT_UNREGISTER;
    else c.action = htq_pkg::ACT_POLL;
    // Mostly use current tokens of slots below the slot count, with a compact time range so polls expire timers.
    if ($urandom_range(9) < 8) begin
      sl = $urandom_range(live_slots - 1);
      c.slot = 6'(sl);
      c.generation = tmr_gen[sl];
    end
    if ($urandom_range(9) < 8) begin
      c.deadline = 64'($urandom_range(1000));
      c.now_time = 64'($urandom_range(1000));
      c.max_expiries = 6'($urandom_range(8));
    end
    return c;
  endfunction

  initial begin
    row_t rows [$];
    row_t rw;
    htq_pkg::res_t exp_first;
    int sizes [5] = '{64, 1, 5, 0, 100};
    set_slot_count(7'd64);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    rw.has_exp = 1'b1;
    exp_first = mk(htq_pkg::KIND_SUMMARY, htq_pkg::STAT_OK);
    exp_first.last = 1'b1;
    rw.c = mkc(htq_pkg::ACT_POLL, 0, 0, 0, '1, 63);        rw.first = exp_first; rows.push_back(rw);
    exp_first = mk(htq_pkg::KIND_REPLY, htq_pkg::STAT_OK);
    exp_first.token_generation = 1;
    exp_first.last = 1'b1;
    rw.c = mkc(htq_pkg::ACT_REGISTER, 0, 0, 0, 0, 0);      rw.first = exp_first; rows.push_back(rw);
    exp_first = mk(htq_pkg::KIND_REPLY, htq_pkg::STAT_STALE);
    exp_first.last = 1'b1;
    rw.c = mkc(htq_pkg::ACT_ARM, 63, 1, 5, 0, 0);          rw.first = exp_first; rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_UNREGISTER, 0, '1, 0, 0, 0);   rw.first = exp_first; rows.push_back(rw);
    rw.has_exp = 1'b0;
    rw.c = mkc(htq_pkg::ACT_ARM, 0, 1, 0, 0, 0);           rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_ARM, 0, 1, '1, 0, 0);          rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_REGISTER, 0, 0, 0, 0, 0);      rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_ARM, 1, 1, '1, 0, 0);          rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_ARM, 1, 1, 64'd10, 0, 0);      rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_ARM, 0, 1, 64'd10, 0, 0);      rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_POLL, 0, 0, 0, 64'd10, 0);     rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_POLL, 0, 0, 0, 64'd9, 63);     rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_POLL, 0, 0, 0, '1, 1);         rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_POLL, 0, 0, 0, '1, 63);        rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_ARM, 0, 1, 64'd20, 0, 0);      rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_ARM, 0, 1, 64'd30, 0, 0);      rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_ARM, 0, 1, 64'd0, 0, 0);       rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_UNREGISTER, 1, 1, 0, 0, 0);    rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_REGISTER, 0, 0, 0, 0, 0);      rows.push_back(rw);
    rw.c = mkc(htq_pkg::ACT_UNREGISTER, 1, 2, 0, 0, 0);    rows.push_back(rw);

    foreach (rows[i]) begin
      send_command(rows[i].c);
      if (rows[i].has_exp) begin
        exp_first = pending_results[pending_results.size() - 1];
        if (exp_first !== rows[i].first) begin
          errors++;
          $display("%0t directed row %0d: expected %p predicted %p", $time, i,
                   rows[i].first, exp_first);
        end
      end
    end

    // Full table at slot count 1, then overflow register.
    write_slot_count(7'd1);
    for (int i = 0; i < 3; i++) send_command(mkc(htq_pkg::ACT_REGISTER, 0, 0, 0, 0, 0));
    send_command(mkc(htq_pkg::ACT_ARM, 0, 1, 64'd3, 0, 0));
    send_command(mkc(htq_pkg::ACT_POLL, 0, 0, 0, 64'd3, 63));

    for (int ph = 0; ph < 5; ph++) begin
      write_slot_count(7'(sizes[ph]));
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        3: begin send_idle_pct = 25; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 41; i++) begin
        send_command(random_command());
        if (i == 20) drain_results();
      end
    end

    // Fill a full table, send an arm to every slot, and expire them over two polls of up to 63 expiries each.
    write_slot_count(7'd64);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 64; i++) send_command(mkc(htq_pkg::ACT_REGISTER, 0, 0, 0, 0, 0));
    for (int i = 0; i < 64; i++) begin
      send_command(mkc(htq_pkg::ACT_ARM, 6'(i), tmr_gen[i],
                       64'($urandom_range(3)) << 30, 64'd0, 6'd0));
    end
    send_command(mkc(htq_pkg::ACT_POLL, 0, 0, 0, '1, 63));
    send_command(mkc(htq_pkg::ACT_POLL, 0, 0, 0, '1, 63));

    drain_results();
    $display("Sent directed and random commands over five slot-count settings and");
    $display("checked %0d result beats including %0d expiries.", beats_seen, expiries_seen);
    if (errors == 0) begin
      $display("heap_timer_queue regression: pass");
    end else begin
      $display("heap_timer_queue regression: fail");
    end
    $finish;
  end

endmodule

// ----- heap_timer_queue.f -----
rtl/htq_pkg.sv
rtl/htq_ram.sv
rtl/htq_ctrl.sv
rtl/htq_datapath.sv
rtl/heap_timer_queue.sv
rtl/htq_check.sv
test/heap_timer_queue_tb.sv
